// File: design/lgu_pkg.sv
// Shared types, constants and arithmetic helpers of the loss and gradient unit.
package lgu_pkg;

  localparam int unsigned MaxRows      = 65536;
  localparam int unsigned RowCntW      = $clog2(MaxRows + 1);
  localparam int unsigned LogTableSize = 256;
  localparam int unsigned LogTblBits   = $clog2(LogTableSize);
  localparam int unsigned QDepth       = 2;
  localparam int unsigned QPtrW        = $clog2(QDepth);
  localparam int unsigned DivW         = 64;
  localparam int unsigned DvsW         = 32;
  localparam int unsigned DivCntW      = $clog2(DivW);
  localparam int unsigned LnW          = 22;
  localparam int unsigned ProdW        = 55;
  localparam int unsigned TermW        = 50;

  localparam logic [16:0] OneQ16 = 17'h10000;
  localparam logic [15:0] Ln2Q16 = 16'd45426;
  localparam logic [63:0] Ln2Q32 = 64'd2977044472;
  localparam logic signed [63:0] Max64 = 64'sh7fffffffffffffff;
  localparam logic signed [63:0] Min64 = 64'sh8000000000000000;
  localparam logic signed [31:0] Max32 = 32'sh7fffffff;
  localparam logic signed [31:0] Min32 = 32'sh80000000;

  // Register indexes, decoded from the word address.
  localparam logic RegLossMode = 1'b0;
  localparam logic RegClampEps = 1'b1;

  typedef enum logic [1:0] {
    MODE_MSE = 2'd0,
    MODE_BCE = 2'd1,
    MODE_CE  = 2'd2
  } mode_e;

  typedef struct packed {
    logic signed [31:0] predicted;
    logic signed [31:0] target;
    logic               row_end;
    logic               batch_end;
  } in_t;

  typedef struct packed {
    logic signed [31:0] gradient;
    logic signed [31:0] batch_loss;
    logic               loss_valid;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic [1:0]  loss_mode;
    logic [14:0] clamp_epsilon;
  } cfg_t;

  // One classified element, as it waits between front and back.
  typedef struct packed {
    mode_e              mode;
    logic signed [31:0] t;
    logic [31:0]        ud;
    logic [15:0]        tc;
    logic [15:0]        pc;
    logic [31:0]        at;
    logic [31:0]        ap;
    logic               neg;
    logic               pzero;
    logic signed [31:0] grad;
    logic               gsat;
    logic               row_end;
    logic               batch_end;
  } cls_t;

  typedef struct packed {
    logic signed [31:0] v;
    logic               s;
  } sat_t;

  typedef struct packed {
    logic [3:0]  k;
    logic [15:0] a;
    logic [15:0] diff;
    logic [15:0] rem;
  } ln1_t;

  typedef logic [15:0] ln_tab_t [LogTableSize+1];

  // Entries are ln(1 + i/size), found by repeated squaring and rounded to Q0.16.
  function automatic ln_tab_t build_ln_tab();
    ln_tab_t     tab;
    logic [63:0] y;
    logic [63:0] r;
    for (int i = 0; i <= LogTableSize; i++) begin
      y = (64'd1 << 30) + ((64'(i) << 30) / LogTableSize);
      r = '0;
      if (y >= (64'd1 << 31)) begin
        r = 64'd1 << 30;
      end else begin
        for (int b = 29; b >= 0; b--) begin
          y = (y * y) >> 30;
          if (y >= (64'd1 << 31)) begin
            y = y >> 1;
            r[b] = 1'b1;
          end
        end
      end
      tab[i] = 16'((r * Ln2Q32 + (64'd1 << 45)) >> 46);
    end
    return tab;
  endfunction

  localparam ln_tab_t LnTab = build_ln_tab();

  function automatic sat_t sat32(logic signed [65:0] v);
    sat_t r;
    r.s = 1'b0;
    if (v > 66'sh7fffffff) begin
      r.v = Max32;
      r.s = 1'b1;
    end else if (v < -66'sh80000000) begin
      r.v = Min32;
      r.s = 1'b1;
    end else begin
      r.v = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] clamp_prob(logic signed [31:0] x, logic [15:0] lo,
                                             logic [15:0] hi);
    logic [15:0] r;
    if (x > $signed({16'b0, hi})) begin
      r = hi;
    end else if (x < $signed({16'b0, lo})) begin
      r = lo;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  // First log step: exponent, table pair and interpolation weight.
  function automatic ln1_t ln_stage1(logic [15:0] x);
    ln1_t                s;
    logic [3:0]          k;
    logic [31:0]         sh;
    logic [15:0]         f;
    logic [LogTblBits-1:0] idx;
    logic [LogTblBits:0]   idx1;
    k = '0;
    for (int i = 1; i < 16; i++) begin
      if (x[i]) k = 4'(i);
    end
    sh     = 32'(x) << (5'd16 - {1'b0, k});
    f      = sh[15:0];
    idx    = f[15 -: LogTblBits];
    idx1   = {1'b0, idx} + 1'b1;
    s.k    = k;
    s.a    = LnTab[idx];
    s.diff = LnTab[idx1] - LnTab[idx];
    s.rem  = 16'(32'(f) << LogTblBits);
    return s;
  endfunction

  function automatic logic signed [LnW-1:0] ln_stage2(ln1_t s);
    logic [31:0] ip;
    logic [4:0]  nk;
    logic [20:0] off;
    ip  = 32'(s.diff) * 32'(s.rem);
    nk  = 5'd16 - {1'b0, s.k};
    off = 21'(nk) * 21'(Ln2Q16);
    return $signed(LnW'(s.a)) + $signed(LnW'(ip[31:16])) - $signed(LnW'(off));
  endfunction

endpackage

// File: design/loss_and_gradient_unit_core.sv
// Top level of the loss and gradient unit: register port and channel wiring.
//
// Usage: each input transaction carries one prediction/target pair in Q16.16
// with row and batch end marks; each yields exactly one output transaction with
// the element's gradient. On the batch's last element the output also carries
// the mean loss over counted rows (a rail, or 0 for a 0 sum, if none was
// counted) with loss_valid set, and the sum restarts. Registers loss_mode
// (address 0) and clamp_epsilon (address 4) are written over the APB-style
// port, by the user only while the unit is idle, which is not enforced.
// The back end works on one element at a time and uses one shared 64-step
// divider: squared error needs no division, cross entropy one (none for a
// zero prediction), binary cross entropy two; batch ends with rows add one.
// A two-entry queue behind the input lets the next transactions be taken
// while one is in work, and the output register holds a finished result.
// While out_stall_i is high the output holds, the back end waits and the
// input stalls once the queue fills. Reset clears the loss sum, the row
// count and all valids; the registers return to mode 0 and epsilon 1.
module loss_and_gradient_unit_core import lgu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  in_t         in_data_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  output out_t        out_data_o,
  input  logic        out_stall_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_q;
  logic cfg_we;
  logic q_push, q_full, q_pop, q_valid;
  cls_t q_wdata, q_rdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loss_mode     <= 2'd0;
      cfg_q.clamp_epsilon <= 15'd1;
    end else if (cfg_we) begin
      unique case (paddr[2])
        RegLossMode: cfg_q.loss_mode     <= pwdata[1:0];
        RegClampEps: cfg_q.clamp_epsilon <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegLossMode: prdata = 32'(cfg_q.loss_mode);
      RegClampEps: prdata = 32'(cfg_q.clamp_epsilon);
      default:     prdata = '0;
    endcase
  end

  lgu_front u_front (
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .cfg_i        (cfg_q),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .push_data_o  (q_wdata)
  );

  lgu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_rdata)
  );

  lgu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// File: design/lgu_front.sv
// Input side: takes elements and classifies them by loss mode for the queue.
module lgu_front import lgu_pkg::*; (
  input  logic in_valid_i,
  input  in_t  in_data_i,
  output logic in_stall_o,
  input  cfg_t cfg_i,
  input  logic q_full_i,
  output logic push_o,
  output cls_t push_data_o
);

  logic signed [31:0] p;
  logic signed [31:0] t;
  logic [15:0]        eps;
  logic [15:0]        hi;
  logic signed [32:0] d;
  sat_t               gs_mse;
  mode_e              mode;

  assign p   = in_data_i.predicted;
  assign t   = in_data_i.target;
  assign eps = (cfg_i.clamp_epsilon == '0) ? 16'd1 : {1'b0, cfg_i.clamp_epsilon};
  assign hi  = 16'(OneQ16 - 17'(eps));
  assign d   = $signed({p[31], p}) - $signed({t[31], t});
  assign gs_mse = sat32(66'(d) <<< 1);

  always_comb begin
    unique case (cfg_i.loss_mode)
      MODE_BCE: mode = MODE_BCE;
      MODE_CE:  mode = MODE_CE;
      default:  mode = MODE_MSE;
    endcase
  end

  always_comb begin
    push_data_o           = '0;
    push_data_o.mode      = mode;
    push_data_o.t         = t;
    push_data_o.ud        = d[32] ? 32'(-d) : 32'(d);
    push_data_o.tc        = clamp_prob(t, eps, hi);
    push_data_o.pc        = clamp_prob(p, eps, hi);
    push_data_o.at        = t[31] ? 32'(-t) : 32'(t);
    push_data_o.ap        = p[31] ? 32'(-p) : 32'(p);
    push_data_o.neg       = (t[31] == p[31]);
    push_data_o.pzero     = (p == '0);
    push_data_o.row_end   = in_data_i.row_end;
    push_data_o.batch_end = in_data_i.batch_end;
    push_data_o.grad      = '0;
    push_data_o.gsat      = 1'b0;
    if (mode == MODE_MSE) begin
      push_data_o.grad = gs_mse.v;
      push_data_o.gsat = gs_mse.s;
    end else if (mode == MODE_CE && p == '0) begin
      // A zero divisor pins the gradient to a rail (zero for a zero target).
      push_data_o.gsat = 1'b1;
      if (t > 0) begin
        push_data_o.grad = Min32;
      end else if (t < 0) begin
        push_data_o.grad = Max32;
      end
    end
  end

  assign push_o     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

endmodule

// File: design/lgu_queue.sv
// Short queue of classified elements between the front and the back.
module lgu_queue import lgu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cls_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cls_t data_o
);

  cls_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QPtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i)
    else $error("queue written while full");
`endif

endmodule

// File: design/lgu_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lgu_div import lgu_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    num_q, num_d;
  logic [DvsW-1:0]    rem_q, rem_d;
  logic [DvsW-1:0]    dvs_q, dvs_d;
  logic [DvsW:0]      sh;
  logic               fits;

  assign sh   = {rem_q, num_q[DivW-1]};
  assign fits = (sh >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? DvsW'(sh - {1'b0, dvs_q}) : DvsW'(sh);
      num_d = {num_q[DivW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// File: design/lgu_back.sv
// Execution side: divisions, logs, products, loss accumulation and the result register.
module lgu_back import lgu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  cls_t q_data_i,
  output logic q_pop_o,
  output logic out_valid_o,
  output out_t out_data_o,
  input  logic out_stall_i
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MUL  = 10'b0000000010,
    S_DIVA = 10'b0000000100,
    S_DIVB = 10'b0000001000,
    S_LNA  = 10'b0000010000,
    S_LNB  = 10'b0000100000,
    S_TERM = 10'b0001000000,
    S_ACC  = 10'b0010000000,
    S_BDIV = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_e;

  state_e                    state_q, state_d;
  cls_t                      cur_q, cur_d;
  logic [1:0]                ph_q, ph_d;
  logic                      go_q, go_d;
  logic [63:0]               sq_q, sq_d;
  logic [31:0]               q1_q, q1_d;
  logic signed [31:0]        grad_q, grad_d;
  logic signed [31:0]        loss_q, loss_d;
  logic                      sat_q, sat_d;
  ln1_t                      ln1_q;
  logic signed [LnW-1:0]     lna_q, lna_d;
  logic signed [LnW-1:0]     lnb_q, lnb_d;
  logic signed [ProdW-1:0]   prod_q, prod_d;
  logic signed [TermW-1:0]   term_q, term_d;
  logic signed [63:0]        acc_q, acc_d;
  logic [RowCntW-1:0]        rc_q, rc_d;
  logic                      out_valid_q, out_load;
  out_t                      out_q;

  logic [15:0]               n1, d1, ln_x, ma16, mb16;
  logic [31:0]               m16;
  logic signed [LnW-1:0]     ln_res;
  logic signed [32:0]        ma;
  logic signed [LnW-1:0]     mb;
  logic signed [ProdW-1:0]   prod, psum, pshift;
  logic                      div_done;
  logic [DivW-1:0]           div_quot, dividend;
  logic [DvsW-1:0]           divisor;
  logic [63:0]               acc_mag;
  logic signed [65:0]        q_s;
  sat_t                      gs_ce, gs_bce, gs_loss;
  logic signed [64:0]        sum65;
  logic signed [63:0]        acc_new;
  logic                      acc_ovf;
  logic [RowCntW-1:0]        rc_new;
  logic                      is_bce;

  assign is_bce = (cur_q.mode == MODE_BCE);
  assign n1     = 16'(OneQ16 - 17'(cur_q.tc));
  assign d1     = 16'(OneQ16 - 17'(cur_q.pc));

  // Square of |p-t| in three 16x16 partial products.
  assign ma16 = (ph_q == 2'd0) ? cur_q.ud[15:0] : cur_q.ud[31:16];
  assign mb16 = (ph_q == 2'd2) ? cur_q.ud[31:16] : cur_q.ud[15:0];
  assign m16  = ma16 * mb16;

  assign ln_x   = (state_q == S_LNB) ? d1 : cur_q.pc;
  assign ln_res = ln_stage2(ln1_q);

  assign ma     = !is_bce ? $signed({cur_q.t[31], cur_q.t}) :
                  (ph_q == 2'd0) ? $signed(33'(cur_q.tc)) : $signed(33'(n1));
  assign mb     = (is_bce && ph_q == 2'd1) ? lnb_q : lna_q;
  assign prod   = ma * mb;
  assign psum   = is_bce ? prod_q + prod : prod;
  assign pshift = psum >>> 16;

  assign acc_mag = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);

  always_comb begin
    dividend = acc_mag;
    divisor  = DvsW'(rc_q);
    if (state_q == S_DIVA) begin
      dividend = is_bce ? 64'({n1, 16'b0}) : 64'({cur_q.at, 16'b0});
      divisor  = is_bce ? DvsW'(d1) : cur_q.ap;
    end else if (state_q == S_DIVB) begin
      dividend = 64'({cur_q.tc, 16'b0});
      divisor  = DvsW'(cur_q.pc);
    end
  end

  lgu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (go_q),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign q_s     = $signed({2'b0, div_quot});
  assign gs_ce   = sat32(cur_q.neg ? -q_s : q_s);
  assign gs_bce  = sat32($signed(66'(q1_q)) - $signed(66'(div_quot[31:0])));
  assign gs_loss = sat32(acc_q[63] ? -q_s : q_s);

  assign sum65   = $signed({acc_q[63], acc_q}) + 65'(term_q);
  assign acc_ovf = (sum65[64] != sum65[63]);
  assign acc_new = !acc_ovf ? sum65[63:0] : (sum65[64] ? Min64 : Max64);
  assign rc_new  = (cur_q.row_end && rc_q < RowCntW'(MaxRows)) ? rc_q + 1'b1 : rc_q;

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    ph_d     = ph_q;
    sq_d     = sq_q;
    q1_d     = q1_q;
    grad_d   = grad_q;
    loss_d   = loss_q;
    sat_d    = sat_q;
    lna_d    = lna_q;
    lnb_d    = lnb_q;
    prod_d   = prod_q;
    term_d   = term_q;
    acc_d    = acc_q;
    rc_d     = rc_q;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_data_i;
          grad_d  = q_data_i.grad;
          sat_d   = q_data_i.gsat;
          loss_d  = '0;
          ph_d    = '0;
          unique case (q_data_i.mode)
            MODE_BCE: state_d = S_DIVA;
            MODE_CE:  state_d = q_data_i.pzero ? S_LNA : S_DIVA;
            default:  state_d = S_MUL;
          endcase
        end
      end
      S_MUL: begin
        if (ph_q == 2'd0) begin
          sq_d = 64'(m16);
          ph_d = 2'd1;
        end else if (ph_q == 2'd1) begin
          sq_d = sq_q + (64'(m16) << 17);
          ph_d = 2'd2;
        end else begin
          sq_d    = sq_q + (64'(m16) << 32);
          term_d  = $signed(TermW'(sq_d[63:16]));
          ph_d    = '0;
          state_d = S_ACC;
        end
      end
      S_DIVA: begin
        if (div_done) begin
          if (is_bce) begin
            q1_d    = div_quot[31:0];
            state_d = S_DIVB;
          end else begin
            grad_d  = gs_ce.v;
            sat_d   = sat_q | gs_ce.s;
            state_d = S_LNA;
          end
        end
      end
      S_DIVB: begin
        if (div_done) begin
          grad_d  = gs_bce.v;
          sat_d   = sat_q | gs_bce.s;
          state_d = S_LNA;
        end
      end
      S_LNA: begin
        if (ph_q == 2'd1) begin
          lna_d   = ln_res;
          ph_d    = '0;
          state_d = is_bce ? S_LNB : S_TERM;
        end else begin
          ph_d = 2'd1;
        end
      end
      S_LNB: begin
        if (ph_q == 2'd1) begin
          lnb_d   = ln_res;
          ph_d    = '0;
          state_d = S_TERM;
        end else begin
          ph_d = 2'd1;
        end
      end
      S_TERM: begin
        if (is_bce && ph_q == 2'd0) begin
          prod_d = prod;
          ph_d   = 2'd1;
        end else begin
          term_d  = -TermW'(pshift);
          ph_d    = '0;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        acc_d   = acc_new;
        rc_d    = rc_new;
        sat_d   = sat_q | acc_ovf;
        state_d = S_OUT;
        if (cur_q.batch_end) begin
          if (rc_new == '0) begin
            // No finished row: report the rail that matches the sum's sign, or zero.
            sat_d  = 1'b1;
            loss_d = (acc_new > 0) ? Max32 : ((acc_new < 0) ? Min32 : '0);
            acc_d  = '0;
            rc_d   = '0;
          end else begin
            state_d = S_BDIV;
          end
        end
      end
      S_BDIV: begin
        if (div_done) begin
          loss_d  = gs_loss.v;
          sat_d   = sat_q | gs_loss.s;
          acc_d   = '0;
          rc_d    = '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign go_d = (state_d != state_q) &&
                (state_d == S_DIVA || state_d == S_DIVB || state_d == S_BDIV);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= '0;
      go_q        <= 1'b0;
      acc_q       <= '0;
      rc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      go_q        <= go_d;
      acc_q       <= acc_d;
      rc_q        <= rc_d;
      out_valid_q <= out_load | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    sq_q   <= sq_d;
    q1_q   <= q1_d;
    grad_q <= grad_d;
    loss_q <= loss_d;
    sat_q  <= sat_d;
    ln1_q  <= ln_stage1(ln_x);
    lna_q  <= lna_d;
    lnb_q  <= lnb_d;
    prod_q <= prod_d;
    term_q <= term_d;
    if (out_load) begin
      out_q.gradient   <= grad_q;
      out_q.batch_loss <= loss_q;
      out_q.loss_valid <= cur_q.batch_end;
      out_q.saturated  <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIVA || state_q == S_DIVB || state_q == S_BDIV))
    else $error("divider finished outside a division step");
  a_bdiv_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BDIV |-> cur_q.batch_end && rc_q != '0)
    else $error("batch division without a batch end or rows");
  a_rows_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc_q <= RowCntW'(MaxRows))
    else $error("row count beyond its limit");
`endif

endmodule

// File: tb/tb_loss_and_gradient_unit_core.sv
// Self-checking testbench for the loss and gradient unit core.
`timescale 1ns / 100ps

module tb_loss_and_gradient_unit_core;
  import lgu_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int RandPerPhase = 60;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  in_t         in_data_i;
  logic        in_stall_o;
  logic        out_valid_o;
  out_t        out_data_o;
  logic        out_stall_i;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  loss_and_gradient_unit_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_data_i(in_data_i), .in_stall_o(in_stall_o),
    .out_valid_o(out_valid_o), .out_data_o(out_data_o), .out_stall_i(out_stall_i),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Model state of the unit.
  longint      ln_lut [LogTableSize+1];
  logic [1:0]  cur_mode;
  logic [14:0] cur_eps;
  longint      loss_sum;
  int          rows_seen;

  in_t  elem_queue [$];
  out_t grad_queue [$];
  int   mismatches;
  int   results_seen;
  int   cycles;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void fill_ln_lut();
    longint unsigned y;
    longint unsigned r;
    for (int i = 0; i <= LogTableSize; i++) begin
      y = (64'd1 << 30) + ((64'(i) << 30) / LogTableSize);
      r = 0;
      if (y >= (64'd1 << 31)) begin
        r = 64'd1 << 30;
      end else begin
        for (int b = 29; b >= 0; b--) begin
          y = (y * y) >> 30;
          if (y >= (64'd1 << 31)) begin
            y = y >> 1;
            r = r | (64'd1 << b);
          end
        end
      end
      ln_lut[i] = longint'((r * 64'd2977044472 + (64'd1 << 45)) >> 46);
    end
  endfunction

  function automatic longint clip32(longint v, inout bit s);
    if (v > 64'sd2147483647) begin
      s = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      s = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint bound(longint x, longint lo, longint hi);
    if (x > hi) x = hi;
    if (x < lo) x = lo;
    return x;
  endfunction

  function automatic longint ln_fix(longint x);
    int unsigned ux, k, f, prod, idx, rem;
    longint a, b;
    if (x < 1) x = 1;
    if (x > 65535) x = 65535;
    ux = int'(x);
    k = 0;
    while (k < 15 && (ux >> (k + 1)) != 0) k++;
    f = (ux << (16 - k)) - 32'd65536;
    prod = f * LogTableSize;
    idx = prod >> 16;
    rem = prod & 32'hffff;
    a = ln_lut[idx];
    b = ln_lut[idx + 1];
    a = a + (((b - a) * longint'(rem)) >>> 16);
    return (longint'(k) - 16) * 45426 + a;
  endfunction

  // Gradient and batch loss for one element; updates the loss sum and row count.
  function automatic out_t grad_of(in_t it);
    out_t   o;
    bit     s;
    longint p, t, g, term, lossv, eps, lo, hi, tc, pc, q1, q2, d, mag;
    longint unsigned ud;
    s = 1'b0;
    lossv = 0;
    p = longint'(it.predicted);
    t = longint'(it.target);
    eps = (cur_eps == 0) ? 1 : longint'(cur_eps);
    lo = eps;
    hi = 65536 - eps;
    if (cur_mode == MODE_BCE) begin
      tc = bound(t, lo, hi);
      pc = bound(p, lo, hi);
      q1 = ((65536 - tc) << 16) / (65536 - pc);
      q2 = (tc << 16) / pc;
      g = clip32(q1 - q2, s);
      term = -((tc * ln_fix(pc) + (65536 - tc) * ln_fix(65536 - pc)) >>> 16);
    end else if (cur_mode == MODE_CE) begin
      if (p == 0) begin
        s = 1'b1;
        g = (t > 0) ? -64'sd2147483648 : ((t < 0) ? 64'sd2147483647 : 0);
      end else begin
        mag = ((t < 0 ? -t : t) << 16) / (p < 0 ? -p : p);
        g = clip32(((t < 0) == (p < 0)) ? -mag : mag, s);
      end
      term = -((t * ln_fix(bound(p, lo, hi))) >>> 16);
    end else begin
      d = p - t;
      ud = longint'(d < 0 ? -d : d);
      g = clip32(2 * d, s);
      term = longint'((ud * ud) >> 16);
    end
    if (term > 0 && loss_sum > 64'sh7fffffffffffffff - term) begin
      loss_sum = 64'sh7fffffffffffffff;
      s = 1'b1;
    end else if (term < 0 && loss_sum < 64'sh8000000000000000 - term) begin
      loss_sum = 64'sh8000000000000000;
      s = 1'b1;
    end else begin
      loss_sum = loss_sum + term;
    end
    if (it.row_end && rows_seen < MaxRows) rows_seen++;
    if (it.batch_end) begin
      if (rows_seen == 0) begin
        s = 1'b1;
        lossv = (loss_sum > 0) ? 64'sd2147483647 : ((loss_sum < 0) ? -64'sd2147483648 : 0);
      end else begin
        lossv = clip32(loss_sum / longint'(rows_seen), s);
      end
      loss_sum = 0;
      rows_seen = 0;
    end
    o.gradient = g[31:0];
    o.batch_loss = lossv[31:0];
    o.loss_valid = it.batch_end;
    o.saturated = s;
    return o;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin : drive
      bit busy;
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        grad_queue.push_back(grad_of(elem_queue.pop_front()));
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (elem_queue.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= elem_queue[0];
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern in segments, one long hold-off, and result checking.
  int  seg_left;
  int  seg_kind;
  int  hold_left;
  bit  hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      seg_left <= 0;
      seg_kind <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
      results_seen <= 0;
    end else begin : watch
      out_t want;
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (grad_queue.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction, actual %h", $time, out_data_o);
        end else begin
          want = grad_queue.pop_front();
          if (out_data_o.gradient !== want.gradient)
            $display("%0t: gradient expected %h actual %h", $time,
                     want.gradient, out_data_o.gradient);
          if (out_data_o.batch_loss !== want.batch_loss)
            $display("%0t: batch_loss expected %h actual %h", $time,
                     want.batch_loss, out_data_o.batch_loss);
          if (out_data_o.loss_valid !== want.loss_valid)
            $display("%0t: loss_valid expected %b actual %b", $time,
                     want.loss_valid, out_data_o.loss_valid);
          if (out_data_o.saturated !== want.saturated)
            $display("%0t: saturated expected %b actual %b", $time,
                     want.saturated, out_data_o.saturated);
          if (out_data_o !== want) mismatches++;
        end
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 150 && elem_queue.size() > 10) begin
        // Long hold-off so the internal queue fills and the input stalls.
        hold_done <= 1'b1;
        hold_left <= 400;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left <= $urandom_range(20, 100);
          seg_kind <= $urandom_range(0, 2);
        end else begin
          seg_left <= seg_left - 1;
        end
        case (seg_kind)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (elem_queue.size() != 0 || grad_queue.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic set_mode(logic [1:0] m, logic [14:0] e);
    wait_drained();
    reg_write({RegLossMode, 2'b00}, 32'(m));
    reg_write({RegClampEps, 2'b00}, 32'(e));
    cur_mode = m;
    cur_eps = e;
  endtask

  function automatic in_t elem(logic [31:0] p, logic [31:0] t, bit re, bit be);
    in_t it;
    it.predicted = p;
    it.target = t;
    it.row_end = re;
    it.batch_end = be;
    return it;
  endfunction

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 65536);
      2: return $urandom_range(0, 40);
      3: return 32'd65536 - $urandom_range(0, 40);
      default: return -$urandom_range(0, 70000);
    endcase
  endfunction

  task automatic push_directed();
    elem_queue.push_back(elem(32'h7fffffff, 32'h80000000, 1, 0));
    elem_queue.push_back(elem(32'h80000000, 32'h7fffffff, 0, 0));
    elem_queue.push_back(elem(0, 32'd32768, 0, 0));
    elem_queue.push_back(elem(0, -32'sd5, 1, 0));
    elem_queue.push_back(elem(0, 0, 0, 1));
    // Batch end with no row counted and a nonzero sum.
    elem_queue.push_back(elem(32'd32768, 32'd16384, 0, 1));
    elem_queue.push_back(elem(1, 32'd65535, 1, 0));
    elem_queue.push_back(elem(32'd65535, 1, 1, 1));
  endtask

  task automatic push_random(int n);
    int cnt, rows, len;
    bit be;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 7) == 0) begin
        elem_queue.push_back(elem($urandom, $urandom, $urandom_range(0, 1),
                                  $urandom_range(0, 1)));
        cnt++;
      end else begin
        rows = $urandom_range(1, 5);
        for (int r = 0; r < rows; r++) begin
          len = $urandom_range(1, 4);
          for (int j = 0; j < len; j++) begin
            be = (r == rows - 1) && (j == len - 1);
            // Now and then a batch closes without its row mark.
            elem_queue.push_back(elem(pick_val(), pick_val(), (j == len - 1) &&
                                      !(be && $urandom_range(0, 5) == 0), be));
            cnt++;
          end
        end
      end
    end
  endtask

  initial begin
    mismatches = 0;
    cycles = 0;
    cur_mode = MODE_MSE;
    cur_eps = 15'd1;
    loss_sum = 0;
    rows_seen = 0;
    fill_ln_lut();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_directed();
    push_random(RandPerPhase);
    set_mode(MODE_BCE, 15'd1);
    push_directed();
    push_random(RandPerPhase);
    set_mode(MODE_CE, 15'd32767);
    push_directed();
    push_random(RandPerPhase);
    set_mode(MODE_BCE, 15'd32767);
    push_random(RandPerPhase);
    set_mode(2'd3, 15'd100);
    push_random(RandPerPhase);
    set_mode(MODE_BCE, 15'd0);
    push_random(RandPerPhase);
    set_mode(MODE_CE, 15'd0);
    push_random(RandPerPhase);
    set_mode(MODE_CE, 15'd655);
    push_random(RandPerPhase);
    set_mode(MODE_BCE, 15'd3277);
    push_random(RandPerPhase);
    set_mode(MODE_MSE, 15'd20000);
    push_random(RandPerPhase);

    wait_drained();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
